// ----- rtl/core/jkv_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON key/value extractor package
// Shared types, codes and constants of the extractor.
// ----------------------------------------------------------------------------
package jkv_pkg;

    localparam int KEY_MAX_BYTES_DEF = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THIRD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_KIND = 3'd5;

    localparam logic [1:0] KIND_STRING = 2'd0;
    localparam logic [1:0] KIND_INT    = 2'd1;
    localparam logic [1:0] KIND_BOOL   = 2'd2;

    localparam logic [2:0] ST_BYTE     = 3'd0;
    localparam logic [2:0] ST_STRDONE  = 3'd1;
    localparam logic [2:0] ST_INT      = 3'd2;
    localparam logic [2:0] ST_BOOL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         value_byte;
        logic signed [63:0] int_value;
        logic               bool_value;
        logic               last;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_entry;

    function automatic logic [7:0] true_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = 8'h74;
            2'd1: c = 8'h72;
            2'd2: c = 8'h75;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

    function automatic t_result mk_result(input logic [2:0] st, input logic [7:0] vb,
                                          input logic [63:0] iv, input logic bv,
                                          input logic lst);
        t_result r;
        r.status = st;
        r.value_byte = vb;
        r.int_value = iv;
        r.bool_value = bv;
        r.last = lst;
        return r;
    endfunction

endpackage

// ----- rtl/core/json_key_value_extractor_unit.sv -----
// Path: an accepted byte's results are written into the result queue and
// from there into the output register.
// Throughput: one byte per cycle unless o_in_stall is high; the key window
// match and the decimal accumulate finish in the cycle the byte is accepted.
// A byte that gives two results holds the output for two transfers.
// Reset is synchronous and active low; it clears state and empties the queue.
// ----------------------------------------------------------------------------
// JSON key/value extractor top level
// Connects the front end, the result queue and the output stage.
// ----------------------------------------------------------------------------
module json_key_value_extractor_unit #(
    parameter int KEY_MAX_BYTES = jkv_pkg::KEY_MAX_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jkv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jkv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_end_of_text,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [7:0]                     o_value_byte,
    output logic signed [63:0]             o_int_value,
    output logic                           o_bool_value,
    output logic                           o_last
);
    import jkv_pkg::*;

    logic    push, pop, full, empty;
    t_entry  push_entry, head_entry;
    t_result result;

    assign o_in_stall = full;

    jkv_front #(.KEY_MAX_BYTES(KEY_MAX_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_text_byte(i_text_byte),
        .i_end_of_text(i_end_of_text), .i_full(full),
        .o_push(push), .o_entry(push_entry)
    );

    jkv_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_entry(push_entry), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_entry(head_entry)
    );

    jkv_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_entry(head_entry), .o_pop(pop),
        .i_out_stall(i_out_stall), .o_out_valid(o_out_valid), .o_result(result)
    );

    assign o_status = result.status;
    assign o_value_byte = result.value_byte;
    assign o_int_value = result.int_value;
    assign o_bool_value = result.bool_value;
    assign o_last = result.last;

endmodule

// ----- rtl/core/jkv_front.sv -----
// ----------------------------------------------------------------------------
// JSON extractor front end
// Accepts document bytes, holds the key registers, searches for the key and
// parses the value, producing at most one queue entry of up to two results per byte.
// ----------------------------------------------------------------------------
module jkv_front #(
    parameter int KEY_MAX_BYTES = jkv_pkg::KEY_MAX_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jkv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jkv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_end_of_text,
    input  logic                          i_full,
    output logic                          o_push,
    output jkv_pkg::t_entry               o_entry
);
    import jkv_pkg::*;

    localparam int WIN_DEPTH = KEY_MAX_BYTES + 3;
    localparam int SEEN_W = $clog2(WIN_DEPTH + 1);

    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_SKIPWS = 3'd1;
    localparam logic [2:0] PH_STRING = 3'd2;
    localparam logic [2:0] PH_INT    = 3'd3;
    localparam logic [2:0] PH_BOOL   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [5:0]   r_key_len;
    logic [255:0] r_key;
    logic [1:0]   r_kind;

    logic [7:0]        r_window [WIN_DEPTH];
    logic [7:0]        n_window [WIN_DEPTH];
    logic [7:0]        sh_window [WIN_DEPTH];
    logic [2:0]        r_phase, n_phase;
    logic [SEEN_W-1:0] r_seen, n_seen, sh_seen;
    logic              r_esc, n_esc;
    logic [63:0]       r_acc, n_acc;
    logic              r_neg, n_neg;
    logic              r_sat, n_sat;
    logic              r_int_seen, n_int_seen;
    logic [2:0]        r_tmc, n_tmc;

    logic [6:0] k_eff;
    logic       win_match;
    logic       accept;

    assign accept = i_in_valid && !i_full;
    assign k_eff = (7'(r_key_len) > 7'(KEY_MAX_BYTES)) ? 7'(KEY_MAX_BYTES) : 7'(r_key_len);

    always_comb begin
        logic eq_all;
        logic [7:0] expect_b;
        int j;
        for (int i = WIN_DEPTH - 1; i > 0; i--) begin
            sh_window[i] = r_window[i-1];
        end
        sh_window[0] = i_text_byte;
        sh_seen = (r_seen < SEEN_W'(WIN_DEPTH)) ? r_seen + 1'b1 : r_seen;
        eq_all = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            j = int'(k_eff) + 1 - i;
            if (i == 0) begin
                expect_b = CH_COLON;
            end else if (i == 1 || i == int'(k_eff) + 2) begin
                expect_b = CH_QUOTE;
            end else if (j >= 0 && j < KEY_MAX_BYTES && j < 32) begin
                expect_b = r_key[{5'(j), 3'b000} +: 8];
            end else begin
                expect_b = 8'h00;
            end
            if (i <= int'(k_eff) + 2 && sh_window[i] != expect_b) begin
                eq_all = 1'b0;
            end
        end
        win_match = eq_all && (int'(sh_seen) >= int'(k_eff) + 3);
    end

    always_comb begin
        logic [7:0]  b;
        logic        doc_end;
        logic        p_emit, e_emit;
        t_result     p_res, e_res;
        logic [63:0] s_acc;
        logic        s_neg, s_sat, s_seen;
        logic [2:0]  s_tmc;
        logic [67:0] wide, limit;
        logic [63:0] n_int_res;
        logic        is_space;

        b = i_text_byte;
        doc_end = (b == 8'h00) || i_end_of_text;
        p_emit = 1'b0;
        e_emit = 1'b0;
        p_res = '0;
        e_res = '0;
        n_window = r_window;
        n_phase = r_phase;
        n_seen = r_seen;
        n_esc = r_esc;
        n_acc = r_acc;
        n_neg = r_neg;
        n_sat = r_sat;
        n_int_seen = r_int_seen;
        n_tmc = r_tmc;

        s_acc = (r_phase == PH_SKIPWS) ? 64'd0 : r_acc;
        s_neg = (r_phase == PH_SKIPWS) ? 1'b0 : r_neg;
        s_sat = (r_phase == PH_SKIPWS) ? 1'b0 : r_sat;
        s_seen = (r_phase == PH_SKIPWS) ? 1'b0 : r_int_seen;
        s_tmc = (r_phase == PH_SKIPWS) ? 3'd0 : r_tmc;
        limit = s_neg ? {4'd0, 64'h8000_0000_0000_0000} : {4'd0, 64'h7FFF_FFFF_FFFF_FFFF};
        wide = {1'b0, s_acc, 3'b000} + {3'b000, s_acc, 1'b0} + {60'd0, b - CH_ZERO};
        is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);

        if (accept && b != 8'h00) begin
            if (r_phase == PH_SKIPWS && !is_space) begin
                unique case (r_kind)
                    KIND_STRING: begin
                        if (b == CH_QUOTE) begin
                            n_phase = PH_STRING;
                            n_esc = 1'b0;
                        end else begin
                            p_emit = 1'b1;
                            p_res = mk_result(ST_NOTFOUND, 8'd0, 64'd0, 1'b0, 1'b1);
                            n_phase = PH_DONE;
                        end
                    end
                    KIND_INT: begin
                        n_phase = PH_INT;
                        n_acc = 64'd0;
                        n_neg = 1'b0;
                        n_sat = 1'b0;
                        n_int_seen = 1'b0;
                    end
                    KIND_BOOL: begin
                        n_phase = PH_BOOL;
                        n_tmc = 3'd0;
                    end
                    default: begin
                        p_emit = 1'b1;
                        p_res = mk_result(ST_NOTFOUND, 8'd0, 64'd0, 1'b0, 1'b1);
                        n_phase = PH_DONE;
                    end
                endcase
            end
            unique case (r_phase)
                PH_SEARCH: begin
                    n_window = sh_window;
                    n_seen = sh_seen;
                    if (win_match) begin
                        n_phase = PH_SKIPWS;
                    end
                end
                PH_STRING: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        p_emit = 1'b1;
                        p_res = mk_result(ST_BYTE, b, 64'd0, 1'b0, 1'b0);
                    end else if (b == CH_QUOTE) begin
                        p_emit = 1'b1;
                        p_res = mk_result(ST_STRDONE, 8'd0, 64'd0, 1'b0, 1'b1);
                        n_phase = PH_DONE;
                    end else begin
                        n_esc = (b == CH_BSLASH);
                        p_emit = 1'b1;
                        p_res = mk_result(ST_BYTE, b, 64'd0, 1'b0, 1'b0);
                    end
                end
                default: begin
                end
            endcase
            if ((r_phase == PH_INT) ||
                (r_phase == PH_SKIPWS && !is_space && r_kind == KIND_INT)) begin
                if (!s_seen && (b == CH_PLUS || b == CH_MINUS)) begin
                    n_neg = (b == CH_MINUS);
                    n_int_seen = 1'b1;
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    if (s_sat || wide > limit) begin
                        n_acc = limit[63:0];
                        n_sat = 1'b1;
                    end else begin
                        n_acc = wide[63:0];
                    end
                    n_int_seen = 1'b1;
                end else begin
                    p_emit = 1'b1;
                    p_res = mk_result(ST_INT, 8'd0, s_neg ? 64'd0 - s_acc : s_acc,
                                      1'b0, 1'b1);
                    n_phase = PH_DONE;
                end
            end
            if ((r_phase == PH_BOOL) ||
                (r_phase == PH_SKIPWS && !is_space && r_kind == KIND_BOOL)) begin
                if (s_tmc < 3'd4 && b == true_char(s_tmc[1:0])) begin
                    n_tmc = s_tmc + 3'd1;
                    if (s_tmc == 3'd3) begin
                        p_emit = 1'b1;
                        p_res = mk_result(ST_BOOL, 8'd0, 64'd0, 1'b1, 1'b1);
                        n_phase = PH_DONE;
                    end
                end else begin
                    p_emit = 1'b1;
                    p_res = mk_result(ST_BOOL, 8'd0, 64'd0, 1'b0, 1'b1);
                    n_phase = PH_DONE;
                end
            end
        end

        n_int_res = n_neg ? 64'd0 - n_acc : n_acc;
        if (accept && doc_end) begin
            e_emit = 1'b1;
            unique case (n_phase)
                PH_SEARCH: e_res = mk_result(ST_NOTFOUND, 8'd0, 64'd0, 1'b0, 1'b1);
                PH_SKIPWS: begin
                    if (r_kind == KIND_INT) begin
                        e_res = mk_result(ST_INT, 8'd0, 64'd0, 1'b0, 1'b1);
                    end else if (r_kind == KIND_BOOL) begin
                        e_res = mk_result(ST_BOOL, 8'd0, 64'd0, 1'b0, 1'b1);
                    end else begin
                        e_res = mk_result(ST_NOTFOUND, 8'd0, 64'd0, 1'b0, 1'b1);
                    end
                end
                PH_STRING: e_res = mk_result(ST_STRDONE, 8'd0, 64'd0, 1'b0, 1'b1);
                PH_INT: e_res = mk_result(ST_INT, 8'd0, n_int_res, 1'b0, 1'b1);
                PH_BOOL: e_res = mk_result(ST_BOOL, 8'd0, 64'd0, 1'b0, 1'b1);
                default: e_emit = 1'b0;
            endcase
            for (int i = 0; i < WIN_DEPTH; i++) begin
                n_window[i] = 8'h00;
            end
            n_phase = PH_SEARCH;
            n_seen = '0;
            n_esc = 1'b0;
            n_acc = 64'd0;
            n_neg = 1'b0;
            n_sat = 1'b0;
            n_int_seen = 1'b0;
            n_tmc = 3'd0;
        end

        o_push = accept && (p_emit || e_emit);
        o_entry.two = p_emit && e_emit;
        o_entry.res0 = p_emit ? p_res : e_res;
        o_entry.res1 = e_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= '0;
            r_key <= '0;
            r_kind <= '0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_window[i] <= 8'h00;
            end
            r_phase <= PH_SEARCH;
            r_seen <= '0;
            r_esc <= 1'b0;
            r_acc <= 64'd0;
            r_neg <= 1'b0;
            r_sat <= 1'b0;
            r_int_seen <= 1'b0;
            r_tmc <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_LEN: r_key_len <= i_cfg_data[5:0];
                    CFG_KEY_LOW: r_key[63:0] <= i_cfg_data;
                    CFG_KEY_SECOND: r_key[127:64] <= i_cfg_data;
                    CFG_KEY_THIRD: r_key[191:128] <= i_cfg_data;
                    CFG_KEY_HIGH: r_key[255:192] <= i_cfg_data;
                    CFG_VALUE_KIND: r_kind <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
            r_window <= n_window;
            r_phase <= n_phase;
            r_seen <= n_seen;
            r_esc <= n_esc;
            r_acc <= n_acc;
            r_neg <= n_neg;
            r_sat <= n_sat;
            r_int_seen <= n_int_seen;
            r_tmc <= n_tmc;
        end
    end

endmodule

// ----- rtl/core/jkv_queue.sv -----
// ----------------------------------------------------------------------------
// JSON extractor result queue
// Two-entry queue between the front end and the output stage.
// ----------------------------------------------------------------------------
module jkv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jkv_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output jkv_pkg::t_entry o_entry
);
    import jkv_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

endmodule

// ----- rtl/core/jkv_back.sv -----
// ----------------------------------------------------------------------------
// JSON extractor output stage
// Unpacks queue entries into single results and holds them in the output
// register until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module jkv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  jkv_pkg::t_entry  i_entry,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output jkv_pkg::t_result o_result
);
    import jkv_pkg::*;

    t_result r_out;
    t_result r_second;
    logic    r_valid;
    logic    r_pend;
    logic    free;

    assign free = !r_valid || !i_out_stall;
    assign o_pop = free && !r_pend && !i_empty;
    assign o_out_valid = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (free) begin
            if (r_pend) begin
                r_out <= r_second;
            end else if (!i_empty) begin
                r_out <= i_entry.res0;
                r_second <= i_entry.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend <= 1'b0;
        end else if (free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend <= 1'b0;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_pend <= i_entry.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/jkv_checker.sv -----
// ----------------------------------------------------------------------------
// JSON extractor port checker
// Watches the top-level ports for output timing and result consistency.
// ----------------------------------------------------------------------------
module jkv_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [63:0] o_int_value,
    input logic        o_last
);
    import jkv_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_int_value))
        else $error("stalled result changed");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_status != ST_BYTE)))
        else $error("last flag does not match status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_NOTFOUND) else $error("status out of range");

endmodule

bind json_key_value_extractor_unit jkv_port_checker u_jkv_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_status(o_status), .o_int_value(o_int_value),
    .o_last(o_last)
);

// ----- test/jkv_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON key/value extractor checker
// Watches the configuration port and both channels of the extractor, predicts
// the results of every accepted text byte and compares each result transfer
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module jkv_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jkv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jkv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_end_of_text,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [2:0]                     i_status,
    input  logic [7:0]                     i_value_byte,
    input  logic signed [63:0]             i_int_value,
    input  logic                           i_bool_value,
    input  logic                           i_last,
    output int                             o_errors,
    output int                             o_pending
);
    import jkv_pkg::*;

    localparam int WIN_DEPTH = KEY_MAX_BYTES_DEF + 3;

    typedef enum logic [2:0] {
        S_SEARCH, S_SKIPWS, S_STRING, S_INT, S_BOOL, S_DONE
    } t_scan_phase;

    logic [5:0]  key_len;
    logic [63:0] key_regs [4];
    logic [1:0]  kind;

    logic [7:0]  window [WIN_DEPTH];
    t_scan_phase scan_phase;
    int          seen;
    logic        esc_pending;
    logic [63:0] magnitude;
    logic        negative;
    logic        sat;
    int          true_count;

    t_result     expected_results [$];

    assign o_pending = expected_results.size();

    function automatic void clear_doc();
        for (int i = 0; i < WIN_DEPTH; i++) window[i] = 8'h00;
        scan_phase = S_SEARCH;
        seen = 0;
        esc_pending = 1'b0;
        magnitude = '0;
        negative = 1'b0;
        sat = 1'b0;
        true_count = 0;
    endfunction

    function automatic void add(logic [2:0] st, logic [7:0] vb, logic [63:0] iv,
                                logic bv, logic lst);
        t_result r;
        r.status = st;
        r.value_byte = vb;
        r.int_value = iv;
        r.bool_value = bv;
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic logic [7:0] pattern_char(int p, int k);
        int i;
        if (p == 0 || p == k + 1) return CH_QUOTE;
        if (p == k + 2) return CH_COLON;
        i = p - 1;
        return key_regs[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic logic key_found();
        int k;
        int len;
        k = (key_len > 6'd32) ? 32 : int'(key_len);
        len = k + 3;
        if (seen < len) return 1'b0;
        for (int p = 0; p < len; p++) begin
            if (window[len - 1 - p] != pattern_char(p, k)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] signed_value();
        return negative ? (64'd0 - magnitude) : magnitude;
    endfunction

    function automatic void int_char(logic [7:0] b);
        logic [63:0] d;
        logic [63:0] limit;
        if (seen == 0 && (b == CH_PLUS || b == CH_MINUS)) begin
            negative = (b == CH_MINUS);
            seen = 1;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            d = 64'(b - CH_ZERO);
            limit = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (sat || magnitude > (limit - d) / 64'd10) begin
                magnitude = limit;
                sat = 1'b1;
            end else begin
                magnitude = magnitude * 64'd10 + d;
            end
            seen = 1;
        end else begin
            add(ST_INT, 8'h00, signed_value(), 1'b0, 1'b1);
            scan_phase = S_DONE;
        end
    endfunction

    function automatic void bool_char(logic [7:0] b);
        if (true_count < 4 && b == true_char(2'(true_count))) begin
            true_count++;
            if (true_count == 4) begin
                add(ST_BOOL, 8'h00, '0, 1'b1, 1'b1);
                scan_phase = S_DONE;
            end
        end else begin
            add(ST_BOOL, 8'h00, '0, 1'b0, 1'b1);
            scan_phase = S_DONE;
        end
    endfunction

    function automatic void scan_char(logic [7:0] b);
        case (scan_phase)
            S_SEARCH: begin
                for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
                window[0] = b;
                if (seen < WIN_DEPTH) seen++;
                if (key_found()) scan_phase = S_SKIPWS;
            end
            S_SKIPWS: begin
                if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))) begin
                    case (kind)
                        KIND_STRING: begin
                            if (b == CH_QUOTE) begin
                                scan_phase = S_STRING;
                                esc_pending = 1'b0;
                            end else begin
                                add(ST_NOTFOUND, 8'h00, '0, 1'b0, 1'b1);
                                scan_phase = S_DONE;
                            end
                        end
                        KIND_INT: begin
                            scan_phase = S_INT;
                            seen = 0;
                            magnitude = '0;
                            negative = 1'b0;
                            sat = 1'b0;
                            int_char(b);
                        end
                        KIND_BOOL: begin
                            scan_phase = S_BOOL;
                            true_count = 0;
                            bool_char(b);
                        end
                        default: begin
                            add(ST_NOTFOUND, 8'h00, '0, 1'b0, 1'b1);
                            scan_phase = S_DONE;
                        end
                    endcase
                end
            end
            S_STRING: begin
                if (esc_pending) begin
                    esc_pending = 1'b0;
                    add(ST_BYTE, b, '0, 1'b0, 1'b0);
                end else if (b == CH_QUOTE) begin
                    add(ST_STRDONE, 8'h00, '0, 1'b0, 1'b1);
                    scan_phase = S_DONE;
                end else begin
                    if (b == CH_BSLASH) esc_pending = 1'b1;
                    add(ST_BYTE, b, '0, 1'b0, 1'b0);
                end
            end
            S_INT: int_char(b);
            S_BOOL: bool_char(b);
            default: ;
        endcase
    endfunction

    function automatic void close_doc();
        case (scan_phase)
            S_SEARCH: add(ST_NOTFOUND, 8'h00, '0, 1'b0, 1'b1);
            S_SKIPWS: begin
                case (kind)
                    KIND_INT: add(ST_INT, 8'h00, '0, 1'b0, 1'b1);
                    KIND_BOOL: add(ST_BOOL, 8'h00, '0, 1'b0, 1'b1);
                    default: add(ST_NOTFOUND, 8'h00, '0, 1'b0, 1'b1);
                endcase
            end
            S_STRING: add(ST_STRDONE, 8'h00, '0, 1'b0, 1'b1);
            S_INT: add(ST_INT, 8'h00, signed_value(), 1'b0, 1'b1);
            S_BOOL: add(ST_BOOL, 8'h00, '0, 1'b0, 1'b1);
            default: ;
        endcase
        clear_doc();
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            key_len = '0;
            for (int i = 0; i < 4; i++) key_regs[i] = '0;
            kind = KIND_STRING;
            clear_doc();
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.status = i_status;
                got.value_byte = i_value_byte;
                got.int_value = i_int_value;
                got.bool_value = i_bool_value;
                got.last = i_last;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %h", $time, got);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        o_errors++;
                    end
                    if (got.value_byte != want.value_byte) begin
                        $display("%0t: value_byte expected %h actual %h",
                                 $time, want.value_byte, got.value_byte);
                        o_errors++;
                    end
                    if (got.int_value != want.int_value) begin
                        $display("%0t: int_value expected %0d actual %0d",
                                 $time, want.int_value, got.int_value);
                        o_errors++;
                    end
                    if (got.bool_value != want.bool_value) begin
                        $display("%0t: bool_value expected %b actual %b",
                                 $time, want.bool_value, got.bool_value);
                        o_errors++;
                    end
                    if (got.last != want.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, got.last);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_LEN: key_len = i_cfg_data[5:0];
                    CFG_KEY_LOW: key_regs[0] = i_cfg_data;
                    CFG_KEY_SECOND: key_regs[1] = i_cfg_data;
                    CFG_KEY_THIRD: key_regs[2] = i_cfg_data;
                    CFG_KEY_HIGH: key_regs[3] = i_cfg_data;
                    CFG_VALUE_KIND: kind = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_text_byte != 8'h00) scan_char(i_text_byte);
                if (i_text_byte == 8'h00 || i_end_of_text) close_doc();
            end
        end
    end

endmodule

// ----- test/json_key_value_extractor_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON key/value extractor testbench
// Streams directed and random JSON documents with random gaps and output
// stalls through the extractor while the checker predicts every result.
// ----------------------------------------------------------------------------
module json_key_value_extractor_unit_tb;
    import jkv_pkg::*;

    typedef logic [7:0] t_text [$];

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_text_byte;
    logic        i_end_of_text;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_value_byte;
    logic signed [63:0] o_int_value;
    logic        o_bool_value;
    logic        o_last;

    int          errors;
    int          pending;
    int          cycles;
    int          bytes_sent;
    logic        no_gaps;
    logic [7:0]  cur_key [32];
    logic [1:0]  cur_kind;

    json_key_value_extractor_unit dut (.*);

    jkv_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_text_byte(i_text_byte), .i_end_of_text(i_end_of_text),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_status(o_status), .i_value_byte(o_value_byte),
        .i_int_value(o_int_value), .i_bool_value(o_bool_value),
        .i_last(o_last), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int n;
        i_out_stall = 1'b0;
        wait (cycles > 1000 && i_in_valid);
        @(negedge i_clk);
        i_out_stall <= 1'b1;
        repeat (400) @(negedge i_clk);
        forever begin
            n = gap_len();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(negedge i_clk);
        end
    end

    task automatic put(input logic [7:0] b, input logic eot);
        int n;
        n = no_gaps ? 0 : gap_len();
        @(negedge i_clk);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_text_byte <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_doc(input t_text q, input logic zero_end);
        for (int i = 0; i < q.size(); i++) put(q[i], !zero_end && i == q.size() - 1);
        if (zero_end || q.size() == 0) put(8'h00, 1'b0);
    endtask

    task automatic send_str(input string s, input logic zero_end);
        t_text q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        send_doc(q, zero_end);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
    endtask

    task automatic configure(input logic [5:0] len, input logic [1:0] kind);
        logic [63:0] w;
        wait_idle();
        write_reg(CFG_KEY_LEN, {$urandom, 26'($urandom), len});
        for (int r = 0; r < 4; r++) begin
            for (int i = 0; i < 8; i++) w[i * 8 +: 8] = cur_key[r * 8 + i];
            write_reg(CFG_KEY_LOW + 3'(r), w);
        end
        write_reg(CFG_VALUE_KIND, {$urandom, 30'($urandom), kind});
        cur_kind = kind;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_key(input string s);
        for (int i = 0; i < 32; i++) cur_key[i] = (i < s.len()) ? s[i] : 8'($urandom);
    endtask

    task automatic build_doc(input int klen, output t_text q);
        int n;
        int r;
        logic [1:0] k;
        q.delete();
        repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(3, 20)) q.push_back(8'($urandom_range(1, 255)));
            return;
        end
        q.push_back(CH_QUOTE);
        for (int i = 0; i < klen; i++) q.push_back(cur_key[i]);
        q.push_back(CH_QUOTE);
        q.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) begin
            r = $urandom_range(0, 2);
            q.push_back(r == 0 ? 8'h20 : (r == 1 ? 8'h09 : 8'h0A));
        end
        k = ($urandom_range(0, 9) == 0) ? 2'($urandom) : cur_kind;
        case (k)
            KIND_STRING: begin
                if ($urandom_range(0, 4) != 0) begin
                    q.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 8)) begin
                        r = $urandom_range(0, 9);
                        if (r == 0) q.push_back(CH_BSLASH);
                        else if (r == 1) q.push_back(CH_QUOTE);
                        else q.push_back(8'($urandom_range(1, 255)));
                    end
                    if ($urandom_range(0, 9) < 7) q.push_back(CH_QUOTE);
                end else begin
                    q.push_back(8'($urandom_range(1, 255)));
                end
            end
            KIND_INT: begin
                r = $urandom_range(0, 9);
                if (r == 0) q.push_back(CH_PLUS);
                else if (r < 3) q.push_back(CH_MINUS);
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(18, 22) : $urandom_range(0, 6);
                repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 9) < 7) q.push_back(8'h2C);
            end
            KIND_BOOL: begin
                n = $urandom_range(0, 1) ? 4 : $urandom_range(0, 3);
                for (int i = 0; i < n; i++) q.push_back(true_char(2'(i)));
                if (n < 4) q.push_back(8'($urandom_range(1, 255)));
            end
            default: q.push_back(8'($urandom_range(1, 255)));
        endcase
        repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(1, 255)));
    endtask

    initial begin
        t_text doc;
        int klen;
        int r;
        cycles = 0;
        bytes_sent = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_text_byte = '0;
        i_end_of_text = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_key("id");
        configure(6'd2, KIND_INT);
        send_str("\"id\":-9223372036854775809,", 1'b0);
        send_str("{\"id\": +99999999999999999999}", 1'b0);
        send_str("\"id\":-", 1'b0);
        send_str("\"id\":x", 1'b1);
        configure(6'd2, KIND_STRING);
        send_str("\"id\": \"a\\\"b\"", 1'b0);
        send_str("\"id\":5", 1'b0);
        send_str("\"id\":\"abc", 1'b1);
        send_str("abc", 1'b1);
        configure(6'd2, KIND_BOOL);
        send_str("\"id\":true", 1'b0);
        send_str("\"id\":tx", 1'b0);
        configure(6'd2, 2'd3);
        send_str("\"id\": z", 1'b0);
        set_key("");
        configure(6'd0, KIND_INT);
        send_str("\"\":7", 1'b0);

        while (bytes_sent < 1000) begin
            r = $urandom_range(0, 9);
            klen = (r == 0) ? 0 : (r == 1) ? 32 : $urandom_range(1, 4);
            for (int i = 0; i < 32; i++) cur_key[i] = 8'($urandom_range(1, 255));
            configure(($urandom_range(0, 14) == 0) ? 6'($urandom_range(33, 63)) : 6'(klen),
                      2'($urandom));
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10)) begin
                build_doc(klen, doc);
                send_doc(doc, $urandom_range(0, 4) == 0);
            end
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
